// ----- hdl/vatf_pkg.sv -----
`timescale 1ns / 1ps
package vatf_pkg;

    typedef enum logic [2:0] {
        FMT_S8   = 3'd0,
        FMT_U8   = 3'd1,
        FMT_S16  = 3'd2,
        FMT_U16  = 3'd3,
        FMT_S32  = 3'd4,
        FMT_U32  = 3'd5,
        FMT_HALF = 3'd6,
        FMT_F32  = 3'd7
    } fmt_t;

    localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF  = 32'h7F80_0000;

    // leading zero count; 32 for an all-zero word
    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/vatf_int_cvt.sv -----
`timescale 1ns / 1ps
module vatf_int_cvt
    import vatf_pkg::*;
(
    input  logic [31:0] mag,
    input  logic        neg,
    output logic [31:0] result
);
    logic [5:0]  lz;
    logic [31:0] norm_mag;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [24:0] sum;
    logic [7:0]  expo;

    always_comb
    begin
        lz       = clz32(mag);
        norm_mag = mag << lz[4:0];
        guard    = norm_mag[7];
        sticky   = |norm_mag[6:0];
        round_up = guard & (sticky | norm_mag[8]);
        sum      = {1'b0, norm_mag[31:8]} + {24'd0, round_up};
        expo     = 8'(8'd158 - {2'b00, lz} + {7'd0, sum[24]});
        if (mag == 32'd0)
        begin
            result = 32'd0;
        end
        else
        begin
            result = {neg, expo, sum[24] ? sum[23:1] : sum[22:0]};
        end
    end
endmodule

// ----- hdl/vatf_norm_cvt.sv -----
`timescale 1ns / 1ps
module vatf_norm_cvt
    import vatf_pkg::*;
(
    input  logic [15:0] mag,
    input  logic        neg,
    input  fmt_t        fmt,
    output logic [31:0] result
);
    // m / (2^P - 1) is the P-bit pattern of m repeated forever, so the
    // tail past the guard bit is never zero and a tie cannot occur.
    logic [47:0] pattern;
    logic [47:0] shifted;
    logic [59:0] rep15;
    logic [48:0] rep7;
    logic        at_one;
    logic [5:0]  lz;
    logic [24:0] sum;
    logic [7:0]  expo;

    always_comb
    begin
        rep15 = {4{mag[14:0]}};
        rep7  = {7{mag[6:0]}};
        case (fmt)
            FMT_S8:
            begin
                pattern = rep7[48:1];
                at_one  = (mag >= 16'd127);
            end
            FMT_U8:
            begin
                pattern = {6{mag[7:0]}};
                at_one  = (mag == 16'd255);
            end
            FMT_S16:
            begin
                pattern = rep15[59:12];
                at_one  = (mag >= 16'd32767);
            end
            default:
            begin
                pattern = {3{mag}};
                at_one  = (mag == 16'd65535);
            end
        endcase
        lz      = clz32(pattern[47:16]);
        shifted = pattern << lz[4:0];
        sum     = {1'b0, shifted[47:24]} + {24'd0, shifted[23]};
        expo    = 8'(8'd126 - {2'b00, lz} + {7'd0, sum[24]});
        if (mag == 16'd0)
        begin
            result = 32'd0;
        end
        else if (at_one)
        begin
            result = {neg, F32_ONE[30:0]};
        end
        else
        begin
            result = {neg, expo, sum[24] ? sum[23:1] : sum[22:0]};
        end
    end
endmodule

// ----- hdl/vatf_half_cvt.sv -----
`timescale 1ns / 1ps
module vatf_half_cvt
    import vatf_pkg::*;
(
    input  logic [15:0] half,
    output logic [31:0] result
);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [5:0]  lz;
    logic [10:0] sub_man;

    always_comb
    begin
        ex      = half[14:10];
        man     = half[9:0];
        lz      = clz32({man, 22'd0});
        sub_man = {1'b0, man} << (lz[3:0] + 4'd1);
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                result = {half[15], 31'd0};
            end
            else
            begin
                result = {half[15], 8'(8'd112 - {2'b00, lz}), sub_man[9:0], 13'd0};
            end
        end
        else if (ex == 5'h1F)
        begin
            result = {half[15], (man != 10'd0) ? F32_QNAN[30:0] : F32_INF[30:0]};
        end
        else
        begin
            result = {half[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
    end
endmodule

// ----- hdl/vertex_attribute_to_float_core.sv -----
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid / in_stall  | raw_bits[31:0], format[2:0], normalize
// out     | out_valid/ out_stall | value_bits[31:0]
// Two register stages: input register, then result register.
// One word per cycle sustained while out_stall is low; conversion logic sits between the stages.
// rst_n clears only the valid bits; payload registers are not reset.
// A stalled result holds; the input register keeps filling until both
// stages are full, then in_stall rises.
module vertex_attribute_to_float_core
    import vatf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_bits,
    input  logic [2:0]  format,
    input  logic        normalize,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value_bits
);
    logic        s1_valid_reg;
    logic [31:0] raw_reg;
    fmt_t        fmt_reg;
    logic        norm_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        adv2;
    logic        adv1;
    logic [31:0] ext;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] int_res;
    logic [31:0] norm_res;
    logic [31:0] half_res;

    assign adv2      = !out_valid_reg || !out_stall;
    assign adv1      = !s1_valid_reg || adv2;
    assign in_stall  = !adv1;
    assign out_valid = out_valid_reg;
    assign value_bits = value_reg;

    always_comb
    begin
        case (fmt_reg)
            FMT_S8:  ext = {{24{raw_reg[7]}}, raw_reg[7:0]};
            FMT_U8:  ext = {24'd0, raw_reg[7:0]};
            FMT_S16: ext = {{16{raw_reg[15]}}, raw_reg[15:0]};
            FMT_U16: ext = {16'd0, raw_reg[15:0]};
            default: ext = raw_reg;
        endcase
        neg = ext[31] && (fmt_reg == FMT_S8 || fmt_reg == FMT_S16 || fmt_reg == FMT_S32);
        mag = neg ? (32'd0 - ext) : ext;
    end

    vatf_int_cvt u_int (.mag(mag), .neg(neg), .result(int_res));
    vatf_norm_cvt u_norm (.mag(mag[15:0]), .neg(neg), .fmt(fmt_reg), .result(norm_res));
    vatf_half_cvt u_half (.half(raw_reg[15:0]), .result(half_res));

    always_comb
    begin
        case (fmt_reg)
            FMT_F32:  value_next = raw_reg;
            FMT_HALF: value_next = half_res;
            FMT_S32,
            FMT_U32:  value_next = int_res;
            default:  value_next = norm_reg ? norm_res : int_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            raw_reg  <= raw_bits;
            fmt_reg  <= fmt_t'(format);
            norm_reg <= normalize;
        end
        if (adv2 && s1_valid_reg)
        begin
            value_reg <= value_next;
        end
    end

`ifndef SYNTH
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("in_stall without both stages full");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result word repeated");
    a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv2 && fmt_reg == FMT_F32) |=> (value_bits == $past(raw_reg)))
        else $error("float word altered");
`endif
endmodule

// ----- sim/vertex_attribute_to_float_core_test.sv -----
`timescale 1ns / 1ps
module vertex_attribute_to_float_core_test;
    import vatf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] raw_bits;
    logic [2:0]  format;
    logic        normalize;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value_bits;

    logic [31:0] pending_values[$];
    int          error_count = 0;
    int          words_sent;
    int          words_checked = 0;
    bit          idle_enable;
    int          hold_request;
    int          hold_id;

    vertex_attribute_to_float_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_bits   (raw_bits),
        .format     (format),
        .normalize  (normalize),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_bits (value_bits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // sign * num / den correctly rounded to single precision (nearest even)
    function automatic logic [31:0] ratio_to_single(input bit neg,
                                                    input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [127:0] scaled;
        logic [127:0] quo;
        logic [127:0] rest;
        logic [127:0] half;
        logic [24:0]  mant;
        bit           sticky;
        int           msb;
        int           shift;
        int           expo;
        if (num == 64'd0)
            return {neg, 31'd0};
        scaled = {64'd0, num} << 64;
        quo    = scaled / den;
        sticky = (scaled % den) != 0;
        msb = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (quo[i])
                msb = i;
        end
        shift = msb - 23;
        mant  = 25'(quo >> shift);
        rest  = quo & ((128'd1 << shift) - 1);
        half  = 128'd1 << (shift - 1);
        if (rest > half || (rest == half && (sticky || mant[0])))
            mant = mant + 1;
        if (mant[24])
        begin
            mant = mant >> 1;
            msb++;
        end
        expo = msb - 64 + 127;
        return {neg, 8'(expo), mant[22:0]};
    endfunction

    function automatic logic [31:0] expected_float(input logic [31:0] raw,
                                                   input fmt_t fmt,
                                                   input logic norm);
        longint      sv;
        logic [15:0] h;
        case (fmt)
            FMT_S8, FMT_S16:
            begin
                sv = (fmt == FMT_S8) ? longint'($signed(raw[7:0]))
                                     : longint'($signed(raw[15:0]));
                if (norm)
                begin
                    longint den;
                    den = (fmt == FMT_S8) ? 127 : 32767;
                    if (sv < -den)
                        return {1'b1, F32_ONE[30:0]};
                    return ratio_to_single(sv < 0, sv < 0 ? -sv : sv, den);
                end
                return ratio_to_single(sv < 0, sv < 0 ? -sv : sv, 64'd1);
            end
            FMT_U8:
                return ratio_to_single(1'b0, 64'(raw[7:0]), norm ? 64'd255 : 64'd1);
            FMT_U16:
                return ratio_to_single(1'b0, 64'(raw[15:0]), norm ? 64'd65535 : 64'd1);
            FMT_S32:
            begin
                sv = longint'($signed(raw));
                return ratio_to_single(sv < 0, sv < 0 ? -sv : sv, 64'd1);
            end
            FMT_U32:
                return ratio_to_single(1'b0, 64'(raw), 64'd1);
            FMT_HALF:
            begin
                h = raw[15:0];
                if (h[14:10] == 5'h1F)
                    return {h[15], 31'(h[9:0] != 0 ? F32_QNAN : F32_INF)};
                if (h[14:10] == 5'd0)
                    return ratio_to_single(h[15], 64'(h[9:0]), 64'd1 << 24);
                return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
            end
            default:
                return raw;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] raw, input fmt_t fmt, input logic norm);
        int gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        raw_bits  <= raw;
        format    <= fmt;
        normalize <= norm;
        do
            @(posedge clk);
        while (in_stall);
        pending_values = {pending_values, expected_float(raw, fmt, norm)};
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(negedge clk);
    endtask

    // out_stall is redrawn at each falling edge
    initial
    begin
        int stall_left;
        int seen_id;
        out_stall  = 1'b0;
        stall_left = 0;
        seen_id    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_id != seen_id)
            begin
                seen_id    = hold_id;
                stall_left = hold_request;
            end
            else if (stall_left == 0 && idle_enable && !out_stall && $urandom_range(0, 1))
                stall_left = $urandom_range(0, 7);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_values.size() == 0)
            begin
                $error("unexpected word value_bits=%h", value_bits);
                error_count++;
            end
            else
            begin
                logic [31:0] want;
                want = pending_values.pop_front();
                words_checked++;
                if (value_bits !== want)
                begin
                    $error("value_bits: expected %h, actual %h", want, value_bits);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        idle_enable = 1'b0;
        send_word(32'hFFFF_FF80, FMT_S8, 1'b1);   // -128/127 clamps
        send_word(32'h0000_007F, FMT_S8, 1'b1);
        send_word(32'h0000_0000, FMT_S8, 1'b1);   // normalized zero
        send_word(32'hABCD_8000, FMT_S16, 1'b1);  // -32768/32767 clamps
        send_word(32'h0000_7FFF, FMT_S16, 1'b0);
        send_word(32'hFFFF_FFFF, FMT_U8, 1'b1);   // high bits ignored
        send_word(32'h1234_FFFF, FMT_U16, 1'b1);
        send_word(32'h0000_0001, FMT_U16, 1'b1);
        send_word(32'h8000_0000, FMT_S32, 1'b0);
        send_word(32'h7FFF_FFFF, FMT_S32, 1'b1);  // rounds up
        send_word(32'hFFFF_FFFF, FMT_U32, 1'b0);
        send_word(32'h0100_0003, FMT_U32, 1'b0);  // tie, to even
        send_word(32'h0000_7E01, FMT_HALF, 1'b0); // NaN
        send_word(32'h0000_FC00, FMT_HALF, 1'b0); // -inf
        send_word(32'h0000_7C00, FMT_HALF, 1'b1);
        send_word(32'h0000_83FF, FMT_HALF, 1'b0); // subnormal
        send_word(32'h0000_8000, FMT_HALF, 1'b0); // -0
        send_word(32'h0000_7BFF, FMT_HALF, 1'b0);
        send_word(32'h7F80_0001, FMT_F32, 1'b0);  // NaN payload passes
        send_word(32'hFFFF_FFFF, FMT_F32, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [31:0] raw;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                idle_enable = $urandom_range(0, 3) != 0;
            raw = $urandom();
            case ($urandom_range(0, 5))
                0: raw[14:10] = 5'h1F;
                1: raw[14:10] = 5'h00;
                2: raw[30:0] = 31'($urandom_range(0, 255) << $urandom_range(0, 24));
                default: ;
            endcase
            send_word(raw, fmt_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_enable = 1'b0;
        @(negedge clk);
        hold_request = 60;
        hold_id++;
        for (int i = 0; i < 20; i++)
            send_word($urandom(), fmt_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        wait_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_pause_refill();
        idle_enable = 1'b1;
        for (int j = 0; j < 5; j++)
        begin
            for (int i = 0; i < 10; i++)
                send_word($urandom(), fmt_t'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            wait_drained();
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        raw_bits     = 32'd0;
        format       = FMT_S8;
        normalize    = 1'b0;
        words_sent   = 0;
        idle_enable  = 1'b0;
        hold_request = 0;
        hold_id      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random(650);
        test_pause_refill();

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Covered all eight formats, normalize on and off, half NaN/inf/subnormal,");
        $display("stall and gap patterns: %0d words sent, %0d checked.", words_sent,
                 words_checked);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/vatf_pkg.sv
hdl/vatf_int_cvt.sv
hdl/vatf_norm_cvt.sv
hdl/vatf_half_cvt.sv
hdl/vertex_attribute_to_float_core.sv
sim/vertex_attribute_to_float_core_test.sv
